>>> rtl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types for the move-to-front byte codec: controller states, the
// token flags that walk the cell row, and the broadcast command.
// ----------------------------------------------------------------------------
package mtf_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic valid;
    logic done;
  } tok_ctl_t;

  typedef struct packed {
    logic decode;
    logic rebuild;
  } cmd_t;

endpackage

>>> rtl/mtf_if.sv
// ----------------------------------------------------------------------------
// mtf channels
// Valid/ready channels of the move-to-front byte codec: byte requests,
// coded results and the mode register write.
// ----------------------------------------------------------------------------
interface mtf_feed_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       restart;

  modport source (output valid, output in_byte, output restart, input ready);
  modport sink (input valid, input in_byte, input restart, output ready);
endinterface

interface mtf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

interface mtf_cfg_if;
  logic valid;
  logic ready;
  logic decode_mode;

  modport source (output valid, output decode_mode, input ready);
  modport sink (input valid, input decode_mode, output ready);
endinterface

>>> rtl/mtf_cell.sv
// ----------------------------------------------------------------------------
// mtf_cell
// One list position. Holds a symbol and, while a request passes, the token
// with its carried symbol; takes the carried symbol and hands its own on.
// ----------------------------------------------------------------------------
module mtf_cell #(
  parameter int SYMBOL_BITS = 8,
  parameter int IDX         = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mtf_pkg::cmd_t           cmd,
  input  logic [SYMBOL_BITS-1:0]  key,
  input  logic                    wr_en,
  input  logic [SYMBOL_BITS-1:0]  wr_sym,
  input  mtf_pkg::tok_ctl_t       tok_in,
  input  logic [SYMBOL_BITS-1:0]  data_in,
  output mtf_pkg::tok_ctl_t       tok_out,
  output logic [SYMBOL_BITS-1:0]  data_out
);

  localparam logic [SYMBOL_BITS-1:0] HALF = SYMBOL_BITS'(1) << (SYMBOL_BITS - 1);
  localparam logic [SYMBOL_BITS-1:0] POS  = SYMBOL_BITS'(IDX);
  localparam logic [SYMBOL_BITS-1:0] INIT = POS ^ HALF;

  logic [SYMBOL_BITS-1:0] sym;
  mtf_pkg::tok_ctl_t      tok;
  logic [SYMBOL_BITS-1:0] dat;
  logic                   active;
  logic                   hit;
  logic [SYMBOL_BITS-1:0] res;

  assign active = tok.valid && !tok.done;
  assign hit    = active && (cmd.decode ? (POS == key) : (sym == key));
  assign res    = cmd.decode ? sym : (POS ^ HALF);

  always_ff @(posedge clk) begin
    if (rst || cmd.rebuild) begin
      sym <= INIT;
    end else if (wr_en) begin
      sym <= wr_sym;
    end else if (active) begin
      sym <= dat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    dat <= data_in;
  end

  // token leaves done once the symbol is found; it then carries the result
  always_comb begin
    tok_out.valid = tok.valid;
    tok_out.done  = tok.done || hit;
    if (hit) begin
      data_out = res;
    end else if (tok.done) begin
      data_out = dat;
    end else begin
      data_out = sym;
    end
  end

endmodule

>>> rtl/move_to_front_byte_codec_unit.sv
// ----------------------------------------------------------------------------
// move_to_front_byte_codec_unit
// Move-to-front byte codec over a row of list cells, encode or decode
// chosen by the mode register.
//
//   channel  role  payload               handshake
//   feed     sink  in_byte, restart      valid/ready
//   result   src   out_byte              valid/ready
//   cfg      sink  decode_mode           valid/ready, always ready
//
// One request at a time: it walks the row one cell per cycle through the
// whole cell row, the result is registered when the token leaves the last
// cell, and the next request is taken only once that result has been loaded
// into the output register.
// A restart reloads every cell in the accept cycle itself.
// Reset loads the initial list at once; no clearing pass.
// A result waiting on result.ready holds the next request only once that
// request has finished its walk.
// ----------------------------------------------------------------------------
module move_to_front_byte_codec_unit #(
  parameter int SYMBOL_BITS = 8
) (
  input logic         clk,
  input logic         rst,
  mtf_feed_if.sink    feed,
  mtf_result_if.source result,
  mtf_cfg_if.sink     cfg
);

  localparam int N  = 1 << SYMBOL_BITS;
  localparam int MW = (SYMBOL_BITS > 8) ? SYMBOL_BITS : 8;
  localparam logic [SYMBOL_BITS-1:0] HALF = SYMBOL_BITS'(1) << (SYMBOL_BITS - 1);

  mtf_pkg::state_t        state;
  mtf_pkg::state_t        state_next;
  logic                   decode_mode;
  logic [SYMBOL_BITS-1:0] key;
  logic [SYMBOL_BITS-1:0] val_q;
  logic [SYMBOL_BITS-1:0] res;
  logic                   out_valid;
  logic [7:0]             out_byte;

  logic                   acc;
  logic                   exit_tok;
  logic                   load_out;
  logic [MW-1:0]          wide_in;
  logic [MW-1:0]          wide_out;
  logic [SYMBOL_BITS-1:0] val;
  mtf_pkg::cmd_t          cmd;
  logic                   fix_en;
  logic [SYMBOL_BITS-1:0] fix_sym;
  logic [N-1:0]           tok_vec;

  mtf_pkg::tok_ctl_t      chain_tok [N+1];
  logic [SYMBOL_BITS-1:0] chain_dat [N+1];

  assign wide_in  = MW'(feed.in_byte);
  assign val      = wide_in[SYMBOL_BITS-1:0];
  assign acc      = feed.valid && feed.ready;
  assign exit_tok = chain_tok[N].valid;
  assign load_out = (state == mtf_pkg::ST_DONE) && (!out_valid || result.ready);

  assign cmd.decode  = decode_mode;
  assign cmd.rebuild = acc && feed.restart;

  assign chain_tok[0].valid = acc;
  assign chain_tok[0].done  = 1'b0;
  assign chain_dat[0]       = val;

  // front cell gets the moved symbol once the walk is over
  assign fix_en  = exit_tok;
  assign fix_sym = decode_mode ? chain_dat[N] : val_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    mtf_cell #(
      .SYMBOL_BITS(SYMBOL_BITS),
      .IDX        (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .key     (key),
      .wr_en   ((k == 0) ? fix_en : 1'b0),
      .wr_sym  (fix_sym),
      .tok_in  (chain_tok[k]),
      .data_in (chain_dat[k]),
      .tok_out (chain_tok[k+1]),
      .data_out(chain_dat[k+1])
    );
    assign tok_vec[k] = chain_tok[k+1].valid;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mtf_pkg::ST_IDLE: begin
        if (acc) begin
          state_next = mtf_pkg::ST_RUN;
        end
      end
      mtf_pkg::ST_RUN: begin
        if (exit_tok) begin
          state_next = mtf_pkg::ST_DONE;
        end
      end
      mtf_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = mtf_pkg::ST_IDLE;
        end
      end
      default: state_next = mtf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    case (state)
      mtf_pkg::ST_IDLE: feed.ready = 1'b1;
      default:          feed.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
    end else if (cfg.valid) begin
      decode_mode <= cfg.decode_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      key   <= decode_mode ? (val ^ HALF) : val;
      val_q <= val;
    end
    if (exit_tok) begin
      res <= chain_dat[N];
    end
  end

  assign wide_out = MW'(res);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte <= wide_out[7:0];
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign cfg.ready       = 1'b1;

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one request in the cell row");

  a_row_empty: assert property (@(posedge clk) disable iff (rst)
    (state != mtf_pkg::ST_RUN) |-> (tok_vec == '0))
    else $error("token in the cell row outside a walk");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state == mtf_pkg::ST_RUN))
    else $error("accepted request did not start a walk");

  a_found: assert property (@(posedge clk) disable iff (rst)
    exit_tok |-> chain_tok[N].done)
    else $error("request left the row without a match");

endmodule
